[hdl/sit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_pkg
// Shared constants and types for the segment intersection test core.
// ----------------------------------------------------------------------------
package sit_pkg;

  // default coordinate width
  localparam int COORD_WIDTH_DEF = 16;

  // sign of one orientation cross product; both low means zero
  typedef struct packed {
    logic pos;
    logic neg;
  } sit_sign_t;

endpackage

[hdl/sit_orient.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_orient
// Three-stage pipelined orientation: sign of (q - p) x (r - p).
// ----------------------------------------------------------------------------
module sit_orient import sit_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] p_x,
  input  logic signed [COORD_WIDTH-1:0] p_y,
  input  logic signed [COORD_WIDTH-1:0] q_x,
  input  logic signed [COORD_WIDTH-1:0] q_y,
  input  logic signed [COORD_WIDTH-1:0] r_x,
  input  logic signed [COORD_WIDTH-1:0] r_y,
  output sit_sign_t                     sign_o
);

  localparam int DW = COORD_WIDTH + 1;      // difference width
  localparam int PW = 2 * COORD_WIDTH + 2;  // product width
  localparam int CW = 2 * COORD_WIDTH + 3;  // cross product width

  // stage 1: differences
  logic signed [DW-1:0] dqx_r, dqy_r, drx_r, dry_r;
  logic signed [DW-1:0] dqx_nxt, dqy_nxt, drx_nxt, dry_nxt;
  // stage 2: products
  logic signed [PW-1:0] m1_r, m2_r, m1_nxt, m2_nxt;
  // stage 3: sign
  sit_sign_t            sign_r, sign_nxt;
  logic signed [CW-1:0] cross_prod;

  assign dqx_nxt = DW'(q_x) - DW'(p_x);
  assign dqy_nxt = DW'(q_y) - DW'(p_y);
  assign drx_nxt = DW'(r_x) - DW'(p_x);
  assign dry_nxt = DW'(r_y) - DW'(p_y);

  assign m1_nxt = PW'(dqx_r) * PW'(dry_r);
  assign m2_nxt = PW'(drx_r) * PW'(dqy_r);

  always_comb begin
    cross_prod   = CW'(m1_r) - CW'(m2_r);
    sign_nxt.neg = cross_prod[CW-1];
    sign_nxt.pos = !cross_prod[CW-1] && (cross_prod != '0);
  end

  always_ff @(posedge clk) begin
    dqx_r  <= dqx_nxt;
    dqy_r  <= dqy_nxt;
    drx_r  <= drx_nxt;
    dry_r  <= dry_nxt;
    m1_r   <= m1_nxt;
    m2_r   <= m2_nxt;
    sign_r <= sign_nxt;
  end

  assign sign_o = sign_r;

endmodule

[hdl/segment_intersection_test_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Exact 2-D segment intersection test, one segment pair per clock.
// ----------------------------------------------------------------------------
// A word (two segments, A and B, given by their endpoints) is taken at every
// clock edge with start high; busy is always low, so a new word may follow
// in every cycle. The answer appears on out_intersects with out_valid high
// for exactly one cycle, in input order. The receiver cannot stall the
// pipeline: it must take each answer in the cycle it is shown. There are
// four register stages: coordinate differences, the signed multipliers,
// the cross product subtract, and the final combine. Endpoints that touch,
// collinear overlap and a degenerate (point) segment that lies on the
// other segment all count as intersecting.
// ----------------------------------------------------------------------------
module segment_intersection_test_core import sit_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_a_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_end_y,
  output logic                          out_valid,
  output logic                          out_intersects
);

  // The pipeline never stalls.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // valid bits, one per stage
  logic v1_r, v2_r, v3_r, v4_r;

  // Orientation signs:
  //   sa0/sa1: A endpoints against line B
  //   sb0/sb1: B endpoints against line A
  sit_sign_t sa0, sa1, sb0, sb1;

  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_sa0 (
    .clk(clk),
    .p_x(in_b_start_x), .p_y(in_b_start_y),
    .q_x(in_b_end_x),   .q_y(in_b_end_y),
    .r_x(in_a_start_x), .r_y(in_a_start_y),
    .sign_o(sa0)
  );

  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_sa1 (
    .clk(clk),
    .p_x(in_b_start_x), .p_y(in_b_start_y),
    .q_x(in_b_end_x),   .q_y(in_b_end_y),
    .r_x(in_a_end_x),   .r_y(in_a_end_y),
    .sign_o(sa1)
  );

  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_sb0 (
    .clk(clk),
    .p_x(in_a_start_x), .p_y(in_a_start_y),
    .q_x(in_a_end_x),   .q_y(in_a_end_y),
    .r_x(in_b_start_x), .r_y(in_b_start_y),
    .sign_o(sb0)
  );

  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_sb1 (
    .clk(clk),
    .p_x(in_a_start_x), .p_y(in_a_start_y),
    .q_x(in_a_end_x),   .q_y(in_a_end_y),
    .r_x(in_b_end_x),   .r_y(in_b_end_y),
    .sign_o(sb1)
  );

  // Bounding-box membership, computed in stage 1 and carried alongside the
  // orientation pipeline. Bit order: a0 in B, a1 in B, b0 in A, b1 in A.
  function automatic logic in_rng(input logic signed [COORD_WIDTH-1:0] p,
                                  input logic signed [COORD_WIDTH-1:0] q,
                                  input logic signed [COORD_WIDTH-1:0] r);
    in_rng = ((r >= p) && (r <= q)) || ((r >= q) && (r <= p));
  endfunction

  logic [3:0] span_nxt, span1_r, span2_r, span3_r;

  assign span_nxt[0] = in_rng(in_b_start_x, in_b_end_x, in_a_start_x) &&
                       in_rng(in_b_start_y, in_b_end_y, in_a_start_y);
  assign span_nxt[1] = in_rng(in_b_start_x, in_b_end_x, in_a_end_x) &&
                       in_rng(in_b_start_y, in_b_end_y, in_a_end_y);
  assign span_nxt[2] = in_rng(in_a_start_x, in_a_end_x, in_b_start_x) &&
                       in_rng(in_a_start_y, in_a_end_y, in_b_start_y);
  assign span_nxt[3] = in_rng(in_a_start_x, in_a_end_x, in_b_end_x) &&
                       in_rng(in_a_start_y, in_a_end_y, in_b_end_y);

  // Stage 4 combine: proper crossing, or a collinear point inside the span.
  logic cross_a, cross_b, hit_nxt, hit_r;
  logic zero_a0, zero_a1, zero_b0, zero_b1;

  always_comb begin
    cross_a = (sa0.pos && sa1.neg) || (sa0.neg && sa1.pos);
    cross_b = (sb0.pos && sb1.neg) || (sb0.neg && sb1.pos);
    zero_a0 = !sa0.pos && !sa0.neg;
    zero_a1 = !sa1.pos && !sa1.neg;
    zero_b0 = !sb0.pos && !sb0.neg;
    zero_b1 = !sb1.pos && !sb1.neg;
    hit_nxt = (cross_a && cross_b) ||
              (zero_a0 && span3_r[0]) || (zero_a1 && span3_r[1]) ||
              (zero_b0 && span3_r[2]) || (zero_b1 && span3_r[3]);
  end

  // payload registers
  always_ff @(posedge clk) begin
    span1_r <= span_nxt;
    span2_r <= span1_r;
    span3_r <= span2_r;
    hit_r   <= hit_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid      = v4_r;
  assign out_intersects = hit_r;

endmodule

[hdl/sit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks for the segment intersection test core.
// ----------------------------------------------------------------------------
module sit_checker import sit_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] in_a_start_x,
  input logic signed [COORD_WIDTH-1:0] in_a_start_y,
  input logic signed [COORD_WIDTH-1:0] in_b_start_x,
  input logic signed [COORD_WIDTH-1:0] in_b_start_y,
  input logic                          out_valid,
  input logic                          out_intersects
);

  // every answer comes from a matching word that was taken
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 4))
    else $error("answer without a matching word");

  // every word taken out of reset gets its answer
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start && !busy && rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2) &&
     $past(rst_n, 1)) |-> out_valid)
    else $error("word lost");

  // shared start point always intersects
  a_shared_pt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_a_start_x == in_b_start_x &&
                        in_a_start_y == in_b_start_y, 4)) |-> out_intersects)
    else $error("shared endpoint not reported");

endmodule

bind segment_intersection_test_core sit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sit_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_a_start_x(in_a_start_x),
  .in_a_start_y(in_a_start_y),
  .in_b_start_x(in_b_start_x),
  .in_b_start_y(in_b_start_y),
  .out_valid(out_valid),
  .out_intersects(out_intersects)
);

[tb/sv/segment_intersection_test_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_test_core_tb
// Self-checking bench for the segment intersection test core.
// ----------------------------------------------------------------------------
// Segment-pair words are queued up front: a directed set of corner cases
// (crossings, touching endpoints, collinear overlap and gaps, point-sized
// segments, full-scale coordinates), then a random mix that leans on small
// grids and constructed collinear layouts so the zero-orientation paths see
// plenty of traffic. A negedge driver feeds the core with random idle gaps;
// a posedge monitor predicts each accepted word and checks the answers in
// order. The answer strobe cannot be stalled, so only the sender idles.
// ----------------------------------------------------------------------------
module segment_intersection_test_core_tb;
  import sit_pkg::*;

  localparam int CW           = COORD_WIDTH_DEF;
  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_WORDS = 750;
  // four pipeline stages per the core header, plus margin
  localparam int DRAIN_CYCLES = 16;
  // room for ~775 words even if each takes the longest idle gap, several times over
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_pair_t;

  typedef struct packed {
    seg_pair_t pair;
    logic      hit;
  } hit_expect_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  logic out_intersects;

  seg_pair_t cur_pair = '0;

  seg_pair_t   pending_pairs[$];
  hit_expect_t expected_hits[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left    = 0;
  logic        word_taken  = 1'b0;
  logic        burst_mode  = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  segment_intersection_test_core #(
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_a_start_x  (cur_pair.a_start_x),
    .in_a_start_y  (cur_pair.a_start_y),
    .in_a_end_x    (cur_pair.a_end_x),
    .in_a_end_y    (cur_pair.a_end_y),
    .in_b_start_x  (cur_pair.b_start_x),
    .in_b_start_y  (cur_pair.b_start_y),
    .in_b_end_x    (cur_pair.b_end_x),
    .in_b_end_y    (cur_pair.b_end_y),
    .out_valid     (out_valid),
    .out_intersects(out_intersects)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // side of r relative to the directed line p->q: sign of (q-p) x (r-p)
  function automatic sit_sign_t side_of(longint px, longint py, longint qx, longint qy,
                                        longint rx, longint ry);
    longint    cross_prod;
    sit_sign_t s;
    cross_prod = (qx - px) * (ry - py) - (rx - px) * (qy - py);
    s.pos = (cross_prod > 0);
    s.neg = (cross_prod < 0);
    return s;
  endfunction

  function automatic logic on_line(sit_sign_t s);
    return !s.pos && !s.neg;
  endfunction

  function automatic logic straddles(sit_sign_t s0, sit_sign_t s1);
    return (s0.pos && s1.neg) || (s0.neg && s1.pos);
  endfunction

  // r inside the bounding box of p..q
  function automatic logic within_box(longint px, longint py, longint qx, longint qy,
                                      longint rx, longint ry);
    longint lo_x, hi_x, lo_y, hi_y;
    lo_x = (px < qx) ? px : qx;
    hi_x = (px < qx) ? qx : px;
    lo_y = (py < qy) ? py : qy;
    hi_y = (py < qy) ? qy : py;
    return (rx >= lo_x) && (rx <= hi_x) && (ry >= lo_y) && (ry <= hi_y);
  endfunction

  function automatic logic segments_meet(seg_pair_t p);
    longint    ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    sit_sign_t a0_vs_b, a1_vs_b, b0_vs_a, b1_vs_a;
    ax0 = p.a_start_x;  ay0 = p.a_start_y;
    ax1 = p.a_end_x;    ay1 = p.a_end_y;
    bx0 = p.b_start_x;  by0 = p.b_start_y;
    bx1 = p.b_end_x;    by1 = p.b_end_y;
    a0_vs_b = side_of(bx0, by0, bx1, by1, ax0, ay0);
    a1_vs_b = side_of(bx0, by0, bx1, by1, ax1, ay1);
    b0_vs_a = side_of(ax0, ay0, ax1, ay1, bx0, by0);
    b1_vs_a = side_of(ax0, ay0, ax1, ay1, bx1, by1);
    // proper crossing: each segment splits the other's endpoints
    if (straddles(a0_vs_b, a1_vs_b) && straddles(b0_vs_a, b1_vs_a)) return 1'b1;
    // an endpoint on the other line only counts if it is within that segment
    if (on_line(a0_vs_b) && within_box(bx0, by0, bx1, by1, ax0, ay0)) return 1'b1;
    if (on_line(a1_vs_b) && within_box(bx0, by0, bx1, by1, ax1, ay1)) return 1'b1;
    if (on_line(b0_vs_a) && within_box(ax0, ay0, ax1, ay1, bx0, by0)) return 1'b1;
    if (on_line(b1_vs_a) && within_box(ax0, ay0, ax1, ay1, bx1, by1)) return 1'b1;
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.a_start_x = coord_t'(ax0);  p.a_start_y = coord_t'(ay0);
    p.a_end_x   = coord_t'(ax1);  p.a_end_y   = coord_t'(ay1);
    p.b_start_x = coord_t'(bx0);  p.b_start_y = coord_t'(by0);
    p.b_end_x   = coord_t'(bx1);  p.b_end_y   = coord_t'(by1);
    return p;
  endfunction

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // values that sit on the edges of the signed range and around zero
  function automatic int edge_coord();
    case ($urandom_range(0, 6))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  // mostly back-to-back or short gaps, a few long ones; burst mode = no gaps
  function automatic int unsigned next_gap(logic in_burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (in_burst) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents one word at a time, changes inputs at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!start || word_taken)) begin
      if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_pairs.size() != 0) begin
        cur_pair <= pending_pairs.pop_front();
        start    <= 1'b1;
        // occasionally flip between gapped traffic and solid bursts
        if ($urandom_range(0, 39) == 0) burst_mode <= ~burst_mode;
        gap_left <= next_gap(burst_mode);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks answers first, then records the word taken at this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    hit_expect_t exp_hit;
    word_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_hits.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: answer %0b with no word outstanding", out_intersects);
        end else begin
          exp_hit = expected_hits.pop_front();
          if (out_intersects !== exp_hit.hit) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("ERROR: A (%0d,%0d)-(%0d,%0d) B (%0d,%0d)-(%0d,%0d): exp %0b got %0b",
                       exp_hit.pair.a_start_x, exp_hit.pair.a_start_y,
                       exp_hit.pair.a_end_x, exp_hit.pair.a_end_y,
                       exp_hit.pair.b_start_x, exp_hit.pair.b_start_y,
                       exp_hit.pair.b_end_x, exp_hit.pair.b_end_y,
                       exp_hit.hit, out_intersects);
          end
        end
      end
      if (start && !busy) begin
        exp_hit.pair = cur_pair;
        exp_hit.hit  = segments_meet(cur_pair);
        expected_hits.push_back(exp_hit);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build words, release reset, wait for drain, report
  // --------------------------------------------------------------------------
  initial begin
    int        kind, bx, by, dx, dy, ta0, ta1, tb0, tb1, span;
    seg_pair_t p;

    // directed corner cases
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));    // plain X crossing
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 1, 10, 1));      // parallel, apart
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 5, 5, 20, 20));    // collinear overlap
    pending_pairs.push_back(make_pair(0, 0, 4, 4, 5, 5, 9, 9));        // collinear gap
    pending_pairs.push_back(make_pair(0, 0, 5, 5, 5, 5, 9, 9));        // collinear, end to end
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 8));       // T junction
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 1, 5, 8));       // near miss
    pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));        // point on segment
    pending_pairs.push_back(make_pair(3, 4, 3, 4, 0, 0, 6, 6));        // point off segment
    pending_pairs.push_back(make_pair(9, 9, 9, 9, 0, 0, 6, 6));        // point past the end
    pending_pairs.push_back(make_pair(7, -2, 7, -2, 7, -2, 7, -2));    // two equal points
    pending_pairs.push_back(make_pair(7, -2, 7, -2, 7, -3, 7, -3));    // two distinct points
    pending_pairs.push_back(make_pair(2, -5, 2, 5, 2, 4, 2, 9));       // vertical overlap
    pending_pairs.push_back(make_pair(2, -5, 2, 5, 2, 6, 2, 9));       // vertical gap
    pending_pairs.push_back(make_pair(10, 3, -10, 3, 4, 3, -4, 3));    // horizontal, contained
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                      -32768, 32767, 32767, -32768));  // full-scale cross
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, -32768,
                                      -32768, 32767, 32767, 32767));   // full-scale parallel
    pending_pairs.push_back(make_pair(-32768, -32768, 0, 0,
                                      0, 0, 32767, 32767));            // full-scale end to end
    pending_pairs.push_back(make_pair(-32768, -32767, 32767, 32767,
                                      -32767, -32768, 32766, 32767));  // full-scale skinny pair
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                      -32768, -32768, -32768, -32768));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(-32768, 32767, 32767, -32768,
                                      0, 0, 0, 0));                    // point near the middle

    // random mix
    repeat (RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          // full-range noise
          p = make_pair($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
        end
        2, 3: begin
          // tiny grid: touching, T junctions and collinear cases come often
          p = make_pair(rand_in(-3, 3), rand_in(-3, 3), rand_in(-3, 3), rand_in(-3, 3),
                        rand_in(-3, 3), rand_in(-3, 3), rand_in(-3, 3), rand_in(-3, 3));
        end
        4, 5, 6: begin
          // four points on one line: overlap, containment, gaps
          span = ($urandom_range(0, 3) == 0) ? 2000 : 30000;
          dx   = rand_in(-6, 6);
          dy   = rand_in(-6, 6);
          bx   = rand_in(-span, span);
          by   = rand_in(-span, span);
          ta0  = rand_in(-8, 8);  ta1 = rand_in(-8, 8);
          tb0  = rand_in(-8, 8);  tb1 = rand_in(-8, 8);
          p = make_pair(bx + ta0 * dx, by + ta0 * dy, bx + ta1 * dx, by + ta1 * dy,
                        bx + tb0 * dx, by + tb0 * dy, bx + tb1 * dx, by + tb1 * dy);
          // sometimes nudge one point just off the line
          if ($urandom_range(0, 3) == 0) p.b_end_y = p.b_end_y + coord_t'(rand_in(-1, 1));
        end
        7: begin
          // B starts on an endpoint or an interior lattice point of A
          dx  = rand_in(-100, 100);
          dy  = rand_in(-100, 100);
          bx  = rand_in(-20000, 20000);
          by  = rand_in(-20000, 20000);
          ta0 = rand_in(0, 4);
          p = make_pair(bx, by, bx + 4 * dx, by + 4 * dy,
                        bx + ta0 * dx, by + ta0 * dy,
                        rand_in(-32768, 32767), rand_in(-32768, 32767));
        end
        8: begin
          // point-sized segments, against a segment or another point
          bx = rand_in(-5, 5);
          by = rand_in(-5, 5);
          if ($urandom_range(0, 1) == 0)
            p = make_pair(bx, by, bx, by, rand_in(-5, 5), rand_in(-5, 5),
                          rand_in(-5, 5), rand_in(-5, 5));
          else
            p = make_pair(rand_in(-5, 5), rand_in(-5, 5), rand_in(-5, 5), rand_in(-5, 5),
                          bx, by, bx, by);
        end
        default: begin
          // coordinates pinned to the range edges and around zero
          p = make_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                        edge_coord(), edge_coord(), edge_coord(), edge_coord());
        end
      endcase
      pending_pairs.push_back(p);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_pairs.size() != 0 || start || expected_hits.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    // any expectation still waiting is a lost answer
    fail_count += expected_hits.size();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[segment_intersection_test_core.f]
hdl/sit_pkg.sv
hdl/sit_orient.sv
hdl/segment_intersection_test_core.sv
hdl/sit_checker.sv
tb/sv/segment_intersection_test_core_tb.sv
